// ===== rtl/tbc_pkg.sv =====
// Shared types and constants for the tetrahedron barycentric coordinate block.
package tbc_pkg;

   localparam int PT_W       = 20;  // query point field width
   localparam int COORD_BITS = 20;  // coordinate bits read from each field
   localparam int OUT_W      = 32;  // coordinate result width
   localparam int OUT_FRAC   = 16;  // fraction bits of a coordinate
   localparam int NUM_VERTS  = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 60;
   localparam int NUM_DETS   = 4;
   localparam int NUM_ROLES  = 4;

   // Operand sources: vertices 0..3, query point as source 4
   localparam logic [2:0] SRC_Q = 3'd4;

   // Vertex orderings of the element volume and the three sub-volumes
   localparam logic [2:0] DET_SRC [0:NUM_DETS-1][0:NUM_ROLES-1] = '{
      '{3'd0, 3'd1, 3'd2, 3'd3},
      '{3'd3, 3'd0, 3'd2, SRC_Q},
      '{3'd3, 3'd1, 3'd0, SRC_Q},
      '{3'd0, 3'd1, 3'd2, SRC_Q}
   };

   typedef struct packed {
      logic signed [PT_W-1:0] point_x;
      logic signed [PT_W-1:0] point_y;
      logic signed [PT_W-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] coord_xi;
      logic signed [OUT_W-1:0] coord_eta;
      logic signed [OUT_W-1:0] coord_zeta;
      logic                    degenerate;
      logic                    saturated;
   } rsp_type;

endpackage

// ===== rtl/tetrahedron_barycentric_coords.sv =====
// Top level: streaming tetrahedron barycentric coordinates from four configured vertices.
//
//  Channel  Ports                          Direction  Content
//  req      req_valid/req_ready/req_payload  in       query point x y z
//  rsp      rsp_valid/rsp_ready/rsp_payload  out      xi eta zeta, degenerate, saturated
//  csr      csr_we/csr_index/csr_wdata       in       vertex 0..3 packed x y z
//
// One transaction per cycle unless the result stalls, through 41 register stages
// (6 determinant stages; 34 divider stages: operand load, 32 quotient bits, clamp; one
// output register).
// Synchronous reset clears all valid bits and the vertices (a degenerate element).
// A stalled result holds every stage; ready follows the output register's valid bit and rsp_ready.
module tetrahedron_barycentric_coords (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  tbc_pkg::req_type                     req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output tbc_pkg::rsp_type                     rsp_payload,
   input  logic                                 csr_we,
   input  logic [tbc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tbc_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import tbc_pkg::*;

   localparam int CW    = COORD_BITS;
   localparam int PW    = 2 * CW;        // 2x2 product
   localparam int MW    = 2 * CW + 1;    // 2x2 minor
   localparam int SW    = 2 * CW + 3;    // combined minor
   localparam int TW    = 3 * CW + 3;    // cofactor term
   localparam int VW    = 3 * CW + 6;    // six times volume
   localparam int NW    = VW + OUT_FRAC + 1;
   localparam int DLAT  = OUT_W + 2;     // divider register count
   localparam int NSTG  = DLAT + 7;      // valid stages including output register

   typedef logic signed [CW-1:0] crd_type;
   typedef logic signed [PW-1:0] prd_type;
   typedef logic signed [MW-1:0] mnr_type;
   typedef logic signed [SW-1:0] sum_type;
   typedef logic signed [TW-1:0] trm_type;
   typedef logic signed [VW-1:0] vol_type;

   function automatic prd_type mul2(input crd_type x, input crd_type y);
      return PW'(x) * PW'(y);
   endfunction

   function automatic trm_type mul3(input crd_type x, input sum_type y);
      return TW'(x) * TW'(y);
   endfunction

   logic [3*CW-1:0] vertex_ff [0:NUM_VERTS-1];
   logic            vld_ff    [0:NSTG-1];
   logic            en;

   crd_type q0_ff [0:2];
   crd_type q1_ff [0:2];
   crd_type q2_ff [0:2];
   crd_type srca  [0:4][0:2];
   crd_type srcb  [0:4][0:2];
   crd_type pa    [0:NUM_DETS-1][0:NUM_ROLES-1][0:2];
   crd_type pb    [0:NUM_DETS-1][0:NUM_ROLES-1][0:2];

   prd_type prd_in [0:NUM_DETS-1][0:17];
   prd_type prd_ff [0:NUM_DETS-1][0:17];
   mnr_type mnr_in [0:NUM_DETS-1][0:8];
   mnr_type mnr_ff [0:NUM_DETS-1][0:8];
   sum_type sum_in [0:NUM_DETS-1][0:2];
   sum_type sum_ff [0:NUM_DETS-1][0:2];
   trm_type trm_in [0:NUM_DETS-1][0:5];
   trm_type trm_ff [0:NUM_DETS-1][0:5];
   vol_type vol_ff [0:NUM_DETS-1];

   logic [VW-1:0] vmag;
   logic [VW-1:0] smag [1:3];
   logic [NW-1:0] num_in [1:3];
   logic [NW-1:0] num_ff [1:3];
   logic [VW-1:0] den_ff;
   logic          neg_in [1:3];
   logic          neg_ff [1:3];
   logic          dgn_ff;
   logic          dg_ff [0:DLAT-1];

   logic signed [OUT_W-1:0] quo [1:3];
   logic                    sat [1:3];
   rsp_type                 rsp_in;
   rsp_type                 rsp_ff;

   // Advance every stage unless the output holds an unaccepted result
   assign en        = !vld_ff[NSTG-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[NSTG-1];
   assign rsp_payload = rsp_ff;

   // Vertex registers; bits above the three fields are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_VERTS; i++) vertex_ff[i] <= '0;
      end else if (csr_we) begin
         vertex_ff[csr_index] <= csr_wdata[3*CW-1:0];
      end
   end

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSTG; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < NSTG; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // Capture the query point and carry it to the cofactor stage
   always_ff @(posedge clock) begin
      if (en) begin
         q0_ff[0] <= CW'(req_payload.point_x);
         q0_ff[1] <= CW'(req_payload.point_y);
         q0_ff[2] <= CW'(req_payload.point_z);
         q1_ff    <= q0_ff;
         q2_ff    <= q1_ff;
      end
   end

   // Route vertices and query point into each determinant's roles
   always_comb begin
      for (int i = 0; i < NUM_VERTS; i++) begin
         for (int k = 0; k < 3; k++) begin
            srca[i][k] = crd_type'(vertex_ff[i][k*CW +: CW]);
            srcb[i][k] = crd_type'(vertex_ff[i][k*CW +: CW]);
         end
      end
      for (int k = 0; k < 3; k++) begin
         srca[SRC_Q][k] = q0_ff[k];
         srcb[SRC_Q][k] = q2_ff[k];
      end
      for (int j = 0; j < NUM_DETS; j++) begin
         for (int r = 0; r < NUM_ROLES; r++) begin
            for (int k = 0; k < 3; k++) begin
               pa[j][r][k] = srca[DET_SRC[j][r]][k];
               pb[j][r][k] = srcb[DET_SRC[j][r]][k];
            end
         end
      end
   end

   // Stage 1: the 2x2 products; roles are a=0 b=1 c=2 d=3
   always_comb begin
      for (int j = 0; j < NUM_DETS; j++) begin
         prd_in[j][0]  = mul2(pa[j][2][1], pa[j][3][2]);
         prd_in[j][1]  = mul2(pa[j][2][2], pa[j][3][1]);
         prd_in[j][2]  = mul2(pa[j][2][0], pa[j][3][2]);
         prd_in[j][3]  = mul2(pa[j][2][2], pa[j][3][0]);
         prd_in[j][4]  = mul2(pa[j][2][0], pa[j][3][1]);
         prd_in[j][5]  = mul2(pa[j][2][1], pa[j][3][0]);
         prd_in[j][6]  = mul2(pa[j][1][1], pa[j][3][2]);
         prd_in[j][7]  = mul2(pa[j][3][1], pa[j][1][2]);
         prd_in[j][8]  = mul2(pa[j][1][0], pa[j][3][2]);
         prd_in[j][9]  = mul2(pa[j][3][0], pa[j][1][2]);
         prd_in[j][10] = mul2(pa[j][1][0], pa[j][3][1]);
         prd_in[j][11] = mul2(pa[j][1][1], pa[j][3][0]);
         prd_in[j][12] = mul2(pa[j][1][1], pa[j][2][2]);
         prd_in[j][13] = mul2(pa[j][2][1], pa[j][1][2]);
         prd_in[j][14] = mul2(pa[j][1][0], pa[j][2][2]);
         prd_in[j][15] = mul2(pa[j][2][0], pa[j][1][2]);
         prd_in[j][16] = mul2(pa[j][1][0], pa[j][2][1]);
         prd_in[j][17] = mul2(pa[j][2][0], pa[j][1][1]);
      end
   end

   // Stage 2: minors and their combinations
   always_comb begin
      for (int j = 0; j < NUM_DETS; j++) begin
         for (int m = 0; m < 9; m++) begin
            mnr_in[j][m] = MW'(prd_ff[j][2*m]) - MW'(prd_ff[j][2*m+1]);
         end
         for (int m = 0; m < 3; m++) begin
            sum_in[j][m] = SW'(mnr_in[j][m]) - SW'(mnr_in[j][m+3]) + SW'(mnr_in[j][m+6]);
         end
      end
   end

   // Stage 3: cofactor terms
   always_comb begin
      for (int j = 0; j < NUM_DETS; j++) begin
         for (int m = 0; m < 3; m++) begin
            trm_in[j][m]   = mul3(pb[j][1][m], SW'(mnr_ff[j][m]));
            trm_in[j][m+3] = mul3(pb[j][0][m], sum_ff[j][m]);
         end
      end
   end

   // Stage 5 inputs: magnitudes, rounded numerators and signs
   always_comb begin
      vmag = vol_ff[0][VW-1] ? VW'(-vol_ff[0]) : VW'(vol_ff[0]);
      for (int j = 1; j < NUM_DETS; j++) begin
         smag[j]   = vol_ff[j][VW-1] ? VW'(-vol_ff[j]) : VW'(vol_ff[j]);
         num_in[j] = (NW'(smag[j]) << OUT_FRAC) + NW'(vmag >> 1);
         neg_in[j] = vol_ff[j][VW-1] ^ vol_ff[0][VW-1];
      end
   end

   // Determinant pipeline registers
   always_ff @(posedge clock) begin
      if (en) begin
         prd_ff <= prd_in;
         mnr_ff <= mnr_in;
         sum_ff <= sum_in;
         trm_ff <= trm_in;
         for (int j = 0; j < NUM_DETS; j++) begin
            vol_ff[j] <= VW'(trm_ff[j][0]) - VW'(trm_ff[j][1]) + VW'(trm_ff[j][2])
                       - VW'(trm_ff[j][3]) + VW'(trm_ff[j][4]) - VW'(trm_ff[j][5]);
         end
         num_ff <= num_in;
         neg_ff <= neg_in;
         den_ff <= vmag;
         dgn_ff <= (vol_ff[0] == '0);
      end
   end

   // Carry the degenerate flag alongside the dividers
   always_ff @(posedge clock) begin
      if (en) begin
         dg_ff[0] <= dgn_ff;
         for (int i = 1; i < DLAT; i++) dg_ff[i] <= dg_ff[i-1];
      end
   end

   for (genvar j = 1; j < NUM_DETS; j++) begin : g_div
      tbc_div_pipe #(
         .DEN_W (VW),
         .NUM_W (NW)
      ) u_div (
         .clock (clock),
         .en    (en),
         .num   (num_ff[j]),
         .den   (den_ff),
         .neg   (neg_ff[j]),
         .quo   (quo[j]),
         .sat   (sat[j])
      );
   end

   // Zero the result of a flat element
   always_comb begin
      rsp_in.degenerate = dg_ff[DLAT-1];
      if (dg_ff[DLAT-1]) begin
         rsp_in.coord_xi   = '0;
         rsp_in.coord_eta  = '0;
         rsp_in.coord_zeta = '0;
         rsp_in.saturated  = 1'b0;
      end else begin
         rsp_in.coord_xi   = quo[1];
         rsp_in.coord_eta  = quo[2];
         rsp_in.coord_zeta = quo[3];
         rsp_in.saturated  = sat[1] | sat[2] | sat[3];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== rtl/tbc_div_pipe.sv =====
// Pipelined restoring divider giving a saturated signed ratio, one quotient bit per stage.
module tbc_div_pipe #(
   parameter int DEN_W = 66,
   parameter int NUM_W = 83
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic [NUM_W-1:0]             num,
   input  logic [DEN_W-1:0]             den,
   input  logic                         neg,
   output logic signed [tbc_pkg::OUT_W-1:0] quo,
   output logic                         sat
);
   import tbc_pkg::*;

   localparam int QW = OUT_W;
   localparam int RW = DEN_W + QW;

   logic [RW-1:0]    rem_ff [0:QW];
   logic [DEN_W-1:0] den_ff [0:QW];
   logic [QW-1:0]    quo_ff [0:QW];
   logic             ovf_ff [0:QW];
   logic             neg_ff [0:QW];
   logic [QW-1:0]    limit;
   logic [QW-1:0]    mag;
   logic             over;
   logic signed [QW-1:0] quo_out_ff;
   logic             sat_ff;

   // Load numerator, flag a quotient of 2^QW or more
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= RW'(num);
         den_ff[0] <= den;
         quo_ff[0] <= '0;
         ovf_ff[0] <= RW'(num) >= {den, {QW{1'b0}}};
         neg_ff[0] <= neg;
      end
   end

   // One trial subtract per stage, most significant quotient bit first
   for (genvar i = 0; i < QW; i++) begin : g_step
      localparam int K = QW - 1 - i;
      logic [RW-1:0] shifted;
      logic          ge;
      assign shifted = RW'(den_ff[i]) << K;
      assign ge      = rem_ff[i] >= shifted;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i+1] <= ge ? rem_ff[i] - shifted : rem_ff[i];
            den_ff[i+1] <= den_ff[i];
            quo_ff[i+1] <= {quo_ff[i][QW-2:0], ge};
            ovf_ff[i+1] <= ovf_ff[i];
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   // Clamp to the signed range and apply the sign
   always_comb begin
      limit = neg_ff[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      over  = ovf_ff[QW] || (quo_ff[QW] > limit);
      mag   = over ? limit : quo_ff[QW];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_out_ff <= neg_ff[QW] ? $signed(-mag) : $signed(mag);
         sat_ff     <= over;
      end
   end

   assign quo = quo_out_ff;
   assign sat = sat_ff;

endmodule

// ===== rtl/tbc_checker.sv =====
// Port-level checks for the barycentric coordinate block and their bind.
module tbc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input tbc_pkg::req_type               req_payload,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input tbc_pkg::rsp_type               rsp_payload,
   input logic                           csr_we,
   input logic [tbc_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [tbc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tbc_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled transaction changed");

   // Flush results on reset
   a_reset_flush: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Accept input whenever the output is empty
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // Flat element gives zeros without saturation
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.degenerate |->
         rsp_payload.coord_xi == '0 && rsp_payload.coord_eta == '0 &&
         rsp_payload.coord_zeta == '0 && !rsp_payload.saturated)
      else $error("degenerate transaction with nonzero fields");

   // Saturation leaves some coordinate at a range bound
   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.saturated |->
         rsp_payload.coord_xi == 32'sh7fffffff || rsp_payload.coord_xi == 32'sh80000000 ||
         rsp_payload.coord_eta == 32'sh7fffffff || rsp_payload.coord_eta == 32'sh80000000 ||
         rsp_payload.coord_zeta == 32'sh7fffffff || rsp_payload.coord_zeta == 32'sh80000000)
      else $error("saturated flag without clamped coordinate");

endmodule

bind tetrahedron_barycentric_coords tbc_checker u_tbc_checker (.*);

// ===== verif/tbc_coord_checker.sv =====
// Channel monitor, coordinate predictor and result comparison for the barycentric block.
module tbc_coord_checker
   import tbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    error_count,
   output int                    coords_pending
);

   typedef logic signed [127:0] wide_type;
   typedef wide_type            point3_type [3];

   logic [CSR_DATA_W-1:0] vertex_shadow [NUM_VERTS];
   rsp_type               expected_coords [$];

   assign coords_pending = expected_coords.size();

   // Sign-extend one packed coordinate field
   function automatic wide_type widen_coord(logic [COORD_BITS-1:0] f);
      return wide_type'(signed'(f));
   endfunction

   function automatic point3_type unpack_vertex(logic [CSR_DATA_W-1:0] r);
      point3_type p;
      for (int k = 0; k < 3; k++) p[k] = widen_coord(r[k*COORD_BITS +: COORD_BITS]);
      return p;
   endfunction

   // Six times the signed volume of (a,b,c,d), exact
   function automatic wide_type six_volume(point3_type a, point3_type b, point3_type c,
                                           point3_type d);
      wide_type cd_yz, cd_xz, cd_xy, bd_yz, bd_xz, bd_xy, bc_yz, bc_xz, bc_xy;
      cd_yz = c[1]*d[2] - c[2]*d[1];
      cd_xz = c[0]*d[2] - c[2]*d[0];
      cd_xy = c[0]*d[1] - c[1]*d[0];
      bd_yz = b[1]*d[2] - d[1]*b[2];
      bd_xz = b[0]*d[2] - d[0]*b[2];
      bd_xy = b[0]*d[1] - b[1]*d[0];
      bc_yz = b[1]*c[2] - c[1]*b[2];
      bc_xz = b[0]*c[2] - c[0]*b[2];
      bc_xy = b[0]*c[1] - c[0]*b[1];
      return b[0]*cd_yz - b[1]*cd_xz + b[2]*cd_xy
             - a[0]*(cd_yz - bd_yz + bc_yz)
             + a[1]*(cd_xz - bd_xz + bc_xz)
             - a[2]*(cd_xy - bd_xy + bc_xy);
   endfunction

   // Sub-volume over volume with 16 fraction bits, rounded half away from zero
   function automatic logic [OUT_W-1:0] volume_ratio(wide_type num, wide_type den,
                                                      inout logic sat);
      logic         neg;
      logic [127:0] n, d, q, lim;
      neg = num[127] ^ den[127];
      n   = num[127] ? -num : num;
      d   = den[127] ? -den : den;
      q   = ((n << OUT_FRAC) + (d >> 1)) / d;
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (q > lim) begin
         sat = 1'b1;
         q   = lim;
      end
      return neg ? -q[OUT_W-1:0] : q[OUT_W-1:0];
   endfunction

   function automatic rsp_type predict_coords(req_type pt);
      point3_type v0, v1, v2, v3, qp;
      wide_type   vol;
      rsp_type    r;
      logic       sat;
      v0 = unpack_vertex(vertex_shadow[0]);
      v1 = unpack_vertex(vertex_shadow[1]);
      v2 = unpack_vertex(vertex_shadow[2]);
      v3 = unpack_vertex(vertex_shadow[3]);
      qp[0] = widen_coord(pt.point_x[COORD_BITS-1:0]);
      qp[1] = widen_coord(pt.point_y[COORD_BITS-1:0]);
      qp[2] = widen_coord(pt.point_z[COORD_BITS-1:0]);
      r   = '0;
      sat = 1'b0;
      vol = six_volume(v0, v1, v2, v3);
      if (vol == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      r.coord_xi   = volume_ratio(six_volume(v3, v0, v2, qp), vol, sat);
      r.coord_eta  = volume_ratio(six_volume(v3, v1, v0, qp), vol, sat);
      r.coord_zeta = volume_ratio(six_volume(v0, v1, v2, qp), vol, sat);
      r.saturated  = sat;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
      $display("MISMATCH %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   initial error_count = 0;

   // Track vertex writes, queue predictions, compare results
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < NUM_VERTS; i++) vertex_shadow[i] <= '0;
      end else begin
         if (csr_we && csr_index < NUM_VERTS) vertex_shadow[csr_index] <= csr_wdata;
         if (req_valid && req_ready) expected_coords.push_back(predict_coords(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (expected_coords.size() == 0) begin
               report_mismatch("unexpected transaction", '0, '0);
            end else begin
               want = expected_coords.pop_front();
               if (rsp_payload.coord_xi !== want.coord_xi)
                  report_mismatch("coord_xi", rsp_payload.coord_xi, want.coord_xi);
               if (rsp_payload.coord_eta !== want.coord_eta)
                  report_mismatch("coord_eta", rsp_payload.coord_eta, want.coord_eta);
               if (rsp_payload.coord_zeta !== want.coord_zeta)
                  report_mismatch("coord_zeta", rsp_payload.coord_zeta, want.coord_zeta);
               if (rsp_payload.degenerate !== want.degenerate)
                  report_mismatch("degenerate", rsp_payload.degenerate, want.degenerate);
               if (rsp_payload.saturated !== want.saturated)
                  report_mismatch("saturated", rsp_payload.saturated, want.saturated);
            end
         end
      end
   end

endmodule

// ===== verif/tb_tetrahedron_barycentric_coords.sv =====
// Testbench top: stimulus, flow control and verdict for the barycentric coordinate block.
module tb_tetrahedron_barycentric_coords;
   import tbc_pkg::*;

   localparam int FLUSH_CYCLES = 45;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int UNIT         = 1024;
   localparam int PT_MAX       = 524287;
   localparam int PT_MIN       = -524288;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    error_count;
   int                    coords_pending;
   int                    cycle_count = 0;
   int                    burst_left = 0;

   always #1 clock = ~clock;

   tetrahedron_barycentric_coords u_dut (
      .clock, .reset, .req_valid, .req_ready, .req_payload,
      .rsp_valid, .rsp_ready, .rsp_payload, .csr_we, .csr_index, .csr_wdata
   );

   tbc_coord_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_payload,
      .rsp_valid, .rsp_ready, .rsp_payload, .csr_we, .csr_index, .csr_wdata,
      .error_count, .coords_pending
   );

   // Stall the result channel in modes: always ready, random, mostly stalled
   always @(negedge clock) begin
      case ((cycle_count / 97) % 3)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(1, 0) == 1);
         default: rsp_ready <= ($urandom_range(4, 0) == 0);
      endcase
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** tetrahedron_barycentric_coords: FAILED **");
         $finish;
      end
   end

   function automatic logic [CSR_DATA_W-1:0] pack_vertex(int x, int y, int z);
      return {z[PT_W-1:0], y[PT_W-1:0], x[PT_W-1:0]};
   endfunction

   // Write all four vertices on consecutive cycles, then drop the enable
   task automatic load_vertices(logic [CSR_DATA_W-1:0] v0, v1, v2, v3);
      logic [CSR_DATA_W-1:0] v [NUM_VERTS];
      v = '{v0, v1, v2, v3};
      for (int i = 0; i < NUM_VERTS; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= v[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Offer one point, in bursts separated by random gaps
   task automatic send_point(int x, int y, int z);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(8, 1);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20)
                                                  : $urandom_range(12, 1);
      end
      req_valid             <= 1'b1;
      req_payload.point_x   <= x[PT_W-1:0];
      req_payload.point_y   <= y[PT_W-1:0];
      req_payload.point_z   <= z[PT_W-1:0];
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      burst_left--;
   endtask

   // Hold off until every expected result is back, then let the pipe flush
   task automatic drain_results();
      req_valid  <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (coords_pending != 0) @(negedge clock);
      repeat (FLUSH_CYCLES) @(negedge clock);
   endtask

   function automatic int rand_field(int span);
      return (span == 0) ? int'(signed'(PT_W'($urandom)))
                         : $urandom_range(2*span, 0) - span;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_vertex(int span);
      return pack_vertex(rand_field(span), rand_field(span), rand_field(span));
   endfunction

   initial begin
      int span;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset state is a degenerate element
      send_point(0, 0, 0);
      send_point(PT_MAX, PT_MIN, PT_MAX);
      drain_results();

      // Unit element: vertices, centroid, origin and field extremes
      load_vertices(pack_vertex(0, 0, 0), pack_vertex(UNIT, 0, 0),
                    pack_vertex(0, UNIT, 0), pack_vertex(0, 0, UNIT));
      send_point(0, 0, 0);
      send_point(UNIT, 0, 0);
      send_point(0, UNIT, 0);
      send_point(0, 0, UNIT);
      send_point(UNIT/4, UNIT/4, UNIT/4);
      send_point(1, 1, 1);
      send_point(PT_MAX, PT_MAX, PT_MAX);
      send_point(PT_MIN, PT_MIN, PT_MIN);
      send_point(PT_MAX, PT_MIN, -1);
      drain_results();

      // Inverted orientation gives a negative volume
      load_vertices(pack_vertex(0, 0, 0), pack_vertex(0, UNIT, 0),
                    pack_vertex(UNIT, 0, 0), pack_vertex(0, 0, UNIT));
      send_point(UNIT/4, UNIT/4, UNIT/4);
      send_point(-UNIT, UNIT/3, 7);
      send_point(PT_MIN, PT_MAX, PT_MIN);
      drain_results();

      // Tiny volume saturates; coplanar vertices are degenerate
      load_vertices(pack_vertex(0, 0, 0), pack_vertex(1, 0, 0),
                    pack_vertex(0, 1, 0), pack_vertex(0, 0, 1));
      send_point(PT_MAX, PT_MAX, PT_MAX);
      send_point(PT_MIN, PT_MIN, PT_MIN);
      send_point(0, 0, 0);
      drain_results();
      load_vertices(pack_vertex(0, 0, 0), pack_vertex(UNIT, 0, 0),
                    pack_vertex(0, UNIT, 0), pack_vertex(UNIT, UNIT, 0));
      send_point(5, 6, 7);
      send_point(PT_MIN, 0, PT_MAX);
      drain_results();

      // Random elements, small and full range, extreme corners last
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 7)
            load_vertices(pack_vertex(PT_MIN, PT_MIN, PT_MIN),
                          pack_vertex(PT_MAX, PT_MIN, PT_MIN),
                          pack_vertex(PT_MIN, PT_MAX, PT_MIN),
                          pack_vertex(PT_MIN, PT_MIN, PT_MAX));
         else begin
            span = (ph % 2 == 0) ? 4096 : 0;
            load_vertices(rand_vertex(span), rand_vertex(span),
                          rand_vertex(span), rand_vertex(span));
         end
         for (int n = 0; n < 105; n++) begin
            if (ph == 3 && n == 50) drain_results();
            if ($urandom_range(1, 0) == 1)
               send_point(rand_field(0), rand_field(0), rand_field(0));
            else
               send_point(rand_field(8192), rand_field(8192), rand_field(8192));
         end
         drain_results();
      end

      if (error_count == 0)
         $display("** tetrahedron_barycentric_coords: PASSED **");
      else
         $display("** tetrahedron_barycentric_coords: FAILED **");
      $finish;
   end

endmodule
